[hdl/tgemv_pkg.sv]
// shared types, constants and arithmetic helpers of the ternary weight gemv unit
// used by every module of the block; depends on nothing
package tgemv_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int GRP_W      = $clog2(MAX_GROUPS);
  localparam int LANES      = 4;
  localparam int ACT_W      = 16;
  localparam int CODE_W     = 2;
  localparam int WB_W       = LANES * CODE_W;
  localparam int TERM_W     = ACT_W + 2;
  localparam int BSUM_W     = TERM_W + 2;
  localparam int SUM_W      = 32;
  localparam int ROW_W      = 16;
  localparam int RG_W       = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_GROUPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = CFG_IDX_W'(1);

  // reset values of the config registers
  localparam logic [RG_W-1:0]  ROW_GROUPS_RST = RG_W'(1024);
  localparam logic [ROW_W-1:0] ROW_COUNT_RST  = ROW_W'(1);

  // 2-bit weight codes
  localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;
  localparam logic [CODE_W-1:0] CODE_POS  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DBL  = 2'd3;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  typedef logic [LANES-1:0][ACT_W-1:0] acts_t;

  // one queued operation, classified by the front end
  typedef struct packed {
    cmd_t             cmd;
    logic [GRP_W-1:0] grp;
    acts_t            acts;
    logic [WB_W-1:0]  wb;
    logic             row_end;
  } op_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic avail;
    op_t  op;
  } qhead_t;

  function automatic logic signed [TERM_W-1:0] ternary_term(
    input logic [CODE_W-1:0]       code,
    input logic signed [ACT_W-1:0] a
  );
    logic signed [TERM_W-1:0] ax;
    logic signed [TERM_W-1:0] res;
    ax = TERM_W'(a);
    case (code)
      CODE_NEG:  res = -ax;
      CODE_ZERO: res = '0;
      CODE_POS:  res = ax;
      CODE_DBL:  res = ax <<< 1;
      default:   res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] res;
    if (v[SUM_W] != v[SUM_W-1]) begin
      res = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

[hdl/tgemv_front.sv]
// front end: accepts input words, tracks the byte position within a row and
// pushes classified operations into the queue; depends on tgemv_pkg
module tgemv_front import tgemv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    command,
  input  logic [9:0]              group_index,
  input  logic signed [ACT_W-1:0] act0,
  input  logic signed [ACT_W-1:0] act1,
  input  logic signed [ACT_W-1:0] act2,
  input  logic signed [ACT_W-1:0] act3,
  input  logic [WB_W-1:0]         weight_byte,
  input  logic [RG_W-1:0]         row_groups,
  input  logic                    q_full,
  output logic                    push,
  output op_t                     push_op
);

  logic [GRP_W-1:0] byte_pos;
  logic [GRP_W-1:0] byte_pos_next;
  logic [GRP_W:0]   pos_inc;
  logic [RG_W-1:0]  eff_groups;
  logic             accept;
  logic             is_weight;
  logic             load_ok;
  logic             row_end;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign is_weight  = (cmd_t'(command) == CMD_WEIGHT);
  assign load_ok    = (32'(group_index) < 32'(MAX_GROUPS));

  always_comb begin
    if (row_groups == '0) begin
      eff_groups = RG_W'(1);
    end else if (32'(row_groups) > 32'(MAX_GROUPS)) begin
      eff_groups = RG_W'(MAX_GROUPS);
    end else begin
      eff_groups = row_groups;
    end
  end

  assign pos_inc       = {1'b0, byte_pos} + (GRP_W+1)'(1);
  assign row_end       = (32'(pos_inc) >= 32'(eff_groups));
  assign byte_pos_next = row_end ? '0 : pos_inc[GRP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
    end else if (accept && is_weight) begin
      byte_pos <= byte_pos_next;
    end
  end

  // out-of-range loads are dropped here
  assign push = accept && (is_weight || load_ok);

  always_comb begin
    push_op.cmd     = cmd_t'(command);
    push_op.grp     = is_weight ? byte_pos : GRP_W'(group_index);
    push_op.acts[0] = act0;
    push_op.acts[1] = act1;
    push_op.acts[2] = act2;
    push_op.acts[3] = act3;
    push_op.wb      = weight_byte;
    push_op.row_end = row_end;
  end

endmodule

[hdl/tgemv_queue.sv]
// short fifo of classified operations between front and back end
// depends on tgemv_pkg
module tgemv_queue import tgemv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  op_t    push_op,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

  op_t           slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head.avail = (count != '0);
  assign head.op    = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/tgemv_back.sv]
// back end: activation store, ternary multiply-accumulate pipeline, row
// counter and output register; depends on tgemv_pkg
module tgemv_back import tgemv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  qhead_t                  head,
  output logic                    pop,
  input  logic [ROW_W-1:0]        row_count,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic signed [SUM_W-1:0] row_sum,
  output logic [ROW_W-1:0]        row_number,
  output logic                    last_row
);

  acts_t act_mem [MAX_GROUPS];

  logic                     adv;
  acts_t                    rd_acts;
  logic                     v1;
  logic [WB_W-1:0]          wb1;
  logic                     end1;
  logic                     v2;
  logic signed [BSUM_W-1:0] bsum2;
  logic                     end2;
  logic signed [BSUM_W-1:0] bsum;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  acc_sat;
  logic [ROW_W-1:0]         row_counter;
  logic [ROW_W-1:0]         eff_rows;
  logic                     is_last;

  // the whole pipeline holds while a finished word waits
  assign adv = !result_valid || result_ready;
  assign pop = head.avail && adv;

  always_ff @(posedge clk) begin
    if (pop && head.op.cmd == CMD_LOAD) begin
      act_mem[head.op.grp] <= head.op.acts;
    end
    if (adv) begin
      rd_acts <= act_mem[head.op.grp];
    end
  end

  always_comb begin
    bsum = '0;
    for (int l = 0; l < LANES; l++) begin
      bsum = bsum + BSUM_W'(ternary_term(wb1[l*CODE_W +: CODE_W], signed'(rd_acts[l])));
    end
  end

  assign acc_sat  = sat_sum((SUM_W+1)'(acc) + (SUM_W+1)'(bsum2));
  assign eff_rows = (row_count == '0) ? ROW_W'(1) : row_count;
  assign is_last  = (({1'b0, row_counter} + (ROW_W+1)'(1)) >= {1'b0, eff_rows});

  always_ff @(posedge clk) begin
    if (adv) begin
      wb1   <= head.op.wb;
      end1  <= head.op.row_end;
      bsum2 <= bsum;
      end2  <= end1;
      if (v2 && end2) begin
        row_sum    <= acc_sat;
        row_number <= row_counter;
        last_row   <= is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      acc          <= '0;
      row_counter  <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= pop && (head.op.cmd == CMD_WEIGHT);
      v2           <= v1;
      result_valid <= v2 && end2;
      if (v2) begin
        if (end2) begin
          acc         <= '0;
          row_counter <= is_last ? '0 : row_counter + ROW_W'(1);
        end else begin
          acc <= acc_sat;
        end
      end
    end
  end

endmodule

[hdl/ternary_weight_gemv_unit.sv]
// top level of the ternary weight gemv unit: config registers and the
// front end, queue and back end; depends on tgemv_pkg and the tgemv_* modules
//
// usage:
//   item channel (item_valid/item_ready): command 0 writes act0..act3 into
//   group group_index of the activation store; command 1 applies weight_byte
//   (four 2-bit codes, code c is weight c-1) to the group at the current byte
//   position and adds the four products into the saturating row accumulator.
//   after row_groups weight words (clamped to 1..1024) the result channel
//   (result_valid/result_ready) carries row_sum, row_number and last_row.
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   row_groups, index 1 is row_count; cfg_ready is always high. write only
//   while the unit is idle.
//   throughput: one word per cycle while the result channel is not stalled,
//   set by the activation store read and the accumulator add.
//   a row result passes the store read, block sum and output registers.
//   reset clears the position, row counter, accumulator and queue; the store
//   keeps stale data and must be loaded before use.
//   a stalled result holds the back end; the 4-entry queue then fills and
//   item_ready drops.
module ternary_weight_gemv_unit import tgemv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    command,
  input  logic [9:0]              group_index,
  input  logic signed [ACT_W-1:0] act0,
  input  logic signed [ACT_W-1:0] act1,
  input  logic signed [ACT_W-1:0] act2,
  input  logic signed [ACT_W-1:0] act3,
  input  logic [WB_W-1:0]         weight_byte,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic signed [SUM_W-1:0] row_sum,
  output logic [ROW_W-1:0]        row_number,
  output logic                    last_row,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [RG_W-1:0]  row_groups;
  logic [ROW_W-1:0] row_count;
  logic             push;
  op_t              push_op;
  logic             q_full;
  logic             pop;
  qhead_t           head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_groups <= ROW_GROUPS_RST;
      row_count  <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_GROUPS: row_groups <= cfg_data[RG_W-1:0];
        CFG_ROW_COUNT:  row_count  <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  tgemv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .command     (command),
    .group_index (group_index),
    .act0        (act0),
    .act1        (act1),
    .act2        (act2),
    .act3        (act3),
    .weight_byte (weight_byte),
    .row_groups  (row_groups),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  tgemv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .head    (head)
  );

  tgemv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .row_count    (row_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .row_sum      (row_sum),
    .row_number   (row_number),
    .last_row     (last_row)
  );

endmodule

[hdl/tgemv_checker.sv]
// port-level checks of the ternary weight gemv unit, bound to the top level
// depends on tgemv_pkg
module tgemv_port_props import tgemv_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic signed [SUM_W-1:0] row_sum,
  input logic [ROW_W-1:0]        row_number,
  input logic                    last_row
);

  logic [ROW_W-1:0] exp_row;

  // rows come out in order and wrap to zero after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_row <= '0;
    end else if (result_valid && result_ready) begin
      exp_row <= last_row ? '0 : row_number + ROW_W'(1);
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(row_sum)
      && $stable(row_number) && $stable(last_row))
    else $error("result word changed while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> row_number == exp_row)
    else $error("row number out of sequence");

  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind ternary_weight_gemv_unit tgemv_port_props u_tgemv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .row_sum      (row_sum),
  .row_number   (row_number),
  .last_row     (last_row)
);
